### hdl/rssi_distance_estimator_macros.svh
// Assertion macros for the RSSI distance estimator checker.
// No dependencies; included by rde_checker.sv.
`ifndef RSSI_DISTANCE_ESTIMATOR_MACROS_SVH
`define RSSI_DISTANCE_ESTIMATOR_MACROS_SVH

// same-cycle implication
`define RDE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/rde_pkg.sv
// Shared types, constants and helper functions of the RSSI distance estimator.
// No dependencies; used by every RTL file of the block.
package rde_pkg;

   localparam int WINDOW_DEFAULT = 8;

   localparam int RSSI_W     = 8;
   localparam int EXP_W      = 7;
   localparam int DIST_W     = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_RSSI_AT_ONE_METRE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATH_LOSS_EXPONENT = 1'b1;

   localparam logic signed [RSSI_W-1:0] RSSI_AT_ONE_METRE_RESET  = -8'sd59;
   localparam logic [EXP_W-1:0]         PATH_LOSS_EXPONENT_RESET = 7'd32;

   // dB difference and its magnitude
   localparam int DIFF_W = RSSI_W + 1;
   localparam int MAG_W  = RSSI_W + 1;

   // log2(10) in Q.16, times 16 for the Q3.4 exponent
   localparam int               LOG2_TEN_W   = 22;
   localparam logic [LOG2_TEN_W-1:0] LOG2_TEN_X16 = 22'd3483296;

   localparam int Y_NUM_W  = 30;
   localparam int Y_DEN_W  = 11;
   localparam int Y_W      = 28;
   localparam int FRAC_W   = 16;
   localparam int K_W      = Y_W - FRAC_W;
   localparam int M_W      = 18;
   localparam int DELTA_W  = 13;
   localparam int INTERP_W = 12;
   localparam int PROD_W   = DELTA_W + INTERP_W;
   localparam int SHL_MAX  = 7;
   localparam int SHR_W    = 5;

   localparam logic signed [K_W-1:0] K_SATURATE = 12'sd16;
   localparam logic signed [K_W-1:0] K_UNITY    = 12'sd8;
   localparam logic signed [K_W-1:0] K_VANISH   = -12'sd10;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef struct packed {
      logic done;
      logic rem_nonzero;
   } div_status_type;

   typedef enum logic [11:0] {
      S_IDLE       = 12'b0000_0000_0001,
      S_MEDIAN     = 12'b0000_0000_0010,
      S_PRODUCT    = 12'b0000_0000_0100,
      S_YDIV_START = 12'b0000_0000_1000,
      S_YDIV       = 12'b0000_0001_0000,
      S_SIGN       = 12'b0000_0010_0000,
      S_INTERP     = 12'b0000_0100_0000,
      S_SCALE      = 12'b0000_1000_0000,
      S_ACCUM      = 12'b0001_0000_0000,
      S_MEAN_START = 12'b0010_0000_0000,
      S_MEAN_DIV   = 12'b0100_0000_0000,
      S_OUT        = 12'b1000_0000_0000
   } state_type;

   // 2^(i/16) in Q.16
   function automatic logic [M_W-1:0] pow2_frac(input logic [4:0] idx);
      logic [M_W-1:0] v;
      case (idx)
         5'd0:    v = 18'd65536;
         5'd1:    v = 18'd68438;
         5'd2:    v = 18'd71468;
         5'd3:    v = 18'd74632;
         5'd4:    v = 18'd77936;
         5'd5:    v = 18'd81386;
         5'd6:    v = 18'd84990;
         5'd7:    v = 18'd88752;
         5'd8:    v = 18'd92682;
         5'd9:    v = 18'd96785;
         5'd10:   v = 18'd101070;
         5'd11:   v = 18'd105545;
         5'd12:   v = 18'd110218;
         5'd13:   v = 18'd115098;
         5'd14:   v = 18'd120194;
         5'd15:   v = 18'd125515;
         default: v = 18'd131072;
      endcase
      return v;
   endfunction

   function automatic logic signed [RSSI_W-1:0] median3(
      input logic signed [RSSI_W-1:0] a,
      input logic signed [RSSI_W-1:0] b,
      input logic signed [RSSI_W-1:0] c);
      logic signed [RSSI_W-1:0] hi;
      logic signed [RSSI_W-1:0] lo;
      logic signed [RSSI_W-1:0] m;
      hi = (a > b) ? a : b;
      lo = (a > b) ? b : a;
      if (c >= hi) begin
         m = hi;
      end else if (c <= lo) begin
         m = lo;
      end else begin
         m = c;
      end
      return m;
   endfunction

endpackage

### hdl/rssi_distance_estimator.sv
// RSSI distance estimator: median of three, log-distance path loss, moving mean.
// One request is in flight at a time (req_ready only in S_IDLE); the exponent
// uses the 30-step bit-serial divider and the mean is a reciprocal multiply.
// A held result stalls the next one in S_OUT. Synchronous active-high reset
// clears history, ring valid bits, running sum, ring position and config to
// their defaults.
module rssi_distance_estimator #(
   parameter int WINDOW = rde_pkg::WINDOW_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [rde_pkg::RSSI_W-1:0]   req_rssi_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rde_pkg::RSSI_W-1:0]   rsp_median_rssi,
   output logic [rde_pkg::DIST_W-1:0]          rsp_raw_distance,
   output logic [rde_pkg::DIST_W-1:0]          rsp_mean_distance,
   input  logic                                csr_write_enable,
   input  logic [rde_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rde_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int AW          = $clog2(WINDOW);
   localparam int SUM_W       = rde_pkg::DIST_W + $clog2(WINDOW);
   localparam int UP_W        = rde_pkg::M_W + rde_pkg::SHL_MAX;
   localparam int PROD_FULL_W = rde_pkg::MAG_W + rde_pkg::LOG2_TEN_W;

   // floor(sum / WINDOW) = (sum * ceil(2^(SUM_W+AW) / WINDOW)) >> (SUM_W+AW)
   localparam int RECIP_SHIFT = SUM_W + AW;
   localparam int RECIP_W     = SUM_W + 1;
   localparam int MEAN_PROD_W = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] MEAN_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

   rde_pkg::state_type state_ff;
   rde_pkg::state_type state_in;

   logic signed [rde_pkg::RSSI_W-1:0] rssi_at_ff;
   logic [rde_pkg::EXP_W-1:0]         expo_ff;
   logic signed [rde_pkg::RSSI_W-1:0] hist0_ff;
   logic signed [rde_pkg::RSSI_W-1:0] hist1_ff;
   logic signed [rde_pkg::RSSI_W-1:0] hist2_ff;

   logic signed [rde_pkg::RSSI_W-1:0] median_ff;
   logic signed [rde_pkg::RSSI_W-1:0] median_in;
   logic [rde_pkg::DIST_W-1:0]        old_ff;
   logic [rde_pkg::DIST_W-1:0]        old_in;
   logic                              neg_ff;
   logic                              neg_in;
   logic [rde_pkg::Y_NUM_W-1:0]       num_ff;
   logic [rde_pkg::Y_NUM_W-1:0]       num_in;
   logic [rde_pkg::Y_DEN_W-1:0]       den_ff;
   logic [rde_pkg::Y_DEN_W-1:0]       den_in;
   logic [rde_pkg::Y_W-1:0]           y_ff;
   logic [rde_pkg::Y_W-1:0]           y_in;
   logic signed [rde_pkg::K_W-1:0]    k_ff;
   logic [rde_pkg::M_W-1:0]           base_ff;
   logic [rde_pkg::M_W-1:0]           base_in;
   logic [rde_pkg::PROD_W-1:0]        prod_ff;
   logic [rde_pkg::PROD_W-1:0]        prod_in;
   logic [rde_pkg::DIST_W-1:0]        raw_ff;
   logic [rde_pkg::DIST_W-1:0]        raw_in;
   logic [SUM_W-1:0]                  sum_ff;
   logic [SUM_W-1:0]                  sum_in;
   logic [AW-1:0]                     pos_ff;
   logic [AW-1:0]                     pos_in;
   logic [WINDOW-1:0]                 valid_ff;
   logic [MEAN_PROD_W-1:0]            mean_prod_ff;
   logic [MEAN_PROD_W-1:0]            mean_prod_in;
   logic [rde_pkg::DIST_W-1:0]        mean_ff;
   logic [rde_pkg::DIST_W-1:0]        mean_in;

   logic                              rsp_valid_ff;
   logic signed [rde_pkg::RSSI_W-1:0] rsp_median_ff;
   logic [rde_pkg::DIST_W-1:0]        rsp_raw_ff;
   logic [rde_pkg::DIST_W-1:0]        rsp_mean_ff;

   logic                              req_xfer;
   logic                              out_slot_free;
   logic [rde_pkg::DIST_W-1:0]        ram_rd_data;

   logic signed [rde_pkg::DIFF_W-1:0] diff;
   logic [rde_pkg::MAG_W-1:0]         mag;
   logic [PROD_FULL_W-1:0]            prod_full;
   logic [rde_pkg::EXP_W-1:0]         expo_eff;
   logic [rde_pkg::Y_W-1:0]           y_mag;
   logic [3:0]                        tab_idx;
   logic [rde_pkg::M_W-1:0]           tab_next;
   logic [rde_pkg::DELTA_W-1:0]       delta;
   logic [rde_pkg::M_W-1:0]           mant;
   logic [UP_W-1:0]                   scaled_up;
   logic [rde_pkg::K_W-1:0]           shr_full;
   logic [rde_pkg::SHR_W-1:0]         shr;

   logic                              div_start;
   logic [rde_pkg::Y_NUM_W-1:0]       div_quotient;
   rde_pkg::div_status_type           div_status;

   assign req_ready     = (state_ff == rde_pkg::S_IDLE);
   assign req_xfer      = req_valid && req_ready;
   assign out_slot_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rde_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = rde_pkg::S_MEDIAN;
            end
         end
         rde_pkg::S_MEDIAN:     state_in = rde_pkg::S_PRODUCT;
         rde_pkg::S_PRODUCT:    state_in = rde_pkg::S_YDIV_START;
         rde_pkg::S_YDIV_START: state_in = rde_pkg::S_YDIV;
         rde_pkg::S_YDIV: begin
            if (div_status.done) begin
               state_in = rde_pkg::S_SIGN;
            end
         end
         rde_pkg::S_SIGN:       state_in = rde_pkg::S_INTERP;
         rde_pkg::S_INTERP:     state_in = rde_pkg::S_SCALE;
         rde_pkg::S_SCALE:      state_in = rde_pkg::S_ACCUM;
         rde_pkg::S_ACCUM:      state_in = rde_pkg::S_MEAN_START;
         rde_pkg::S_MEAN_START: state_in = rde_pkg::S_MEAN_DIV;
         rde_pkg::S_MEAN_DIV:   state_in = rde_pkg::S_OUT;
         rde_pkg::S_OUT: begin
            if (out_slot_free) begin
               state_in = rde_pkg::S_IDLE;
            end
         end
         default: state_in = rde_pkg::S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      median_in = rde_pkg::median3(hist0_ff, hist1_ff, hist2_ff);
      old_in    = valid_ff[pos_ff] ? ram_rd_data : '0;

      diff      = {rssi_at_ff[rde_pkg::RSSI_W-1], rssi_at_ff}
                - {median_ff[rde_pkg::RSSI_W-1], median_ff};
      neg_in    = diff[rde_pkg::DIFF_W-1];
      mag       = neg_in ? (-diff) : diff;
      prod_full = PROD_FULL_W'(mag) * PROD_FULL_W'(rde_pkg::LOG2_TEN_X16);
      num_in    = prod_full[rde_pkg::Y_NUM_W-1:0];
      expo_eff  = (expo_ff == '0) ? rde_pkg::EXP_W'(1) : expo_ff;
      den_in    = rde_pkg::Y_DEN_W'(expo_eff) * rde_pkg::Y_DEN_W'(10);

      // floor division from magnitude quotient
      y_mag     = {1'b0, div_quotient[rde_pkg::Y_W-2:0]}
                + rde_pkg::Y_W'(neg_ff && div_status.rem_nonzero);
      y_in      = neg_ff ? (-y_mag) : y_mag;

      tab_idx   = y_ff[rde_pkg::FRAC_W-1:rde_pkg::INTERP_W];
      base_in   = rde_pkg::pow2_frac({1'b0, tab_idx});
      tab_next  = rde_pkg::pow2_frac({1'b0, tab_idx} + 5'd1);
      delta     = rde_pkg::DELTA_W'(tab_next - base_in);
      prod_in   = rde_pkg::PROD_W'(delta) * rde_pkg::PROD_W'(y_ff[rde_pkg::INTERP_W-1:0]);

      mant      = base_ff + rde_pkg::M_W'(prod_ff[rde_pkg::PROD_W-1:rde_pkg::INTERP_W]);
      scaled_up = UP_W'(mant) << k_ff[2:0];
      shr_full  = rde_pkg::K_UNITY - k_ff;
      shr       = shr_full[rde_pkg::SHR_W-1:0];
      if (k_ff >= rde_pkg::K_SATURATE) begin
         raw_in = rde_pkg::DIST_MAX;
      end else if (k_ff >= rde_pkg::K_UNITY) begin
         raw_in = (scaled_up > UP_W'(rde_pkg::DIST_MAX)) ? rde_pkg::DIST_MAX
                                                         : scaled_up[rde_pkg::DIST_W-1:0];
      end else if (k_ff <= rde_pkg::K_VANISH) begin
         raw_in = '0;
      end else begin
         raw_in = rde_pkg::DIST_W'(mant >> shr);
      end

      sum_in = sum_ff - SUM_W'(old_ff) + SUM_W'(raw_ff);
      pos_in = (pos_ff == AW'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;

      mean_prod_in = MEAN_PROD_W'(sum_ff) * MEAN_PROD_W'(MEAN_RECIP);
      mean_in      = mean_prod_ff[RECIP_SHIFT+rde_pkg::DIST_W-1:RECIP_SHIFT];
   end

   assign div_start = (state_ff == rde_pkg::S_YDIV_START);

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rde_pkg::S_IDLE;
         rssi_at_ff   <= rde_pkg::RSSI_AT_ONE_METRE_RESET;
         expo_ff      <= rde_pkg::PATH_LOSS_EXPONENT_RESET;
         hist0_ff     <= '0;
         hist1_ff     <= '0;
         hist2_ff     <= '0;
         sum_ff       <= '0;
         pos_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               rde_pkg::CSR_RSSI_AT_ONE_METRE:  rssi_at_ff <= signed'(csr_write_data);
               rde_pkg::CSR_PATH_LOSS_EXPONENT: expo_ff <= csr_write_data[rde_pkg::EXP_W-1:0];
               default: ;
            endcase
         end
         if (req_xfer) begin
            hist2_ff <= hist1_ff;
            hist1_ff <= hist0_ff;
            hist0_ff <= req_rssi_sample;
         end
         if (state_ff == rde_pkg::S_ACCUM) begin
            sum_ff           <= sum_in;
            pos_ff           <= pos_in;
            valid_ff[pos_ff] <= 1'b1;
         end
         if ((state_ff == rde_pkg::S_OUT) && out_slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == rde_pkg::S_MEDIAN) begin
         median_ff <= median_in;
         old_ff    <= old_in;
      end
      if (state_ff == rde_pkg::S_PRODUCT) begin
         neg_ff <= neg_in;
         num_ff <= num_in;
         den_ff <= den_in;
      end
      if (state_ff == rde_pkg::S_SIGN) begin
         y_ff <= y_in;
      end
      if (state_ff == rde_pkg::S_INTERP) begin
         k_ff    <= signed'(y_ff[rde_pkg::Y_W-1:rde_pkg::FRAC_W]);
         base_ff <= base_in;
         prod_ff <= prod_in;
      end
      if (state_ff == rde_pkg::S_SCALE) begin
         raw_ff <= raw_in;
      end
      if (state_ff == rde_pkg::S_MEAN_START) begin
         mean_prod_ff <= mean_prod_in;
      end
      if (state_ff == rde_pkg::S_MEAN_DIV) begin
         mean_ff <= mean_in;
      end
      if ((state_ff == rde_pkg::S_OUT) && out_slot_free) begin
         rsp_median_ff <= median_ff;
         rsp_raw_ff    <= raw_ff;
         rsp_mean_ff   <= mean_ff;
      end
   end

   rde_ram #(
      .WIDTH (rde_pkg::DIST_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == rde_pkg::S_ACCUM),
      .wr_addr (pos_ff),
      .wr_data (raw_ff),
      .rd_en   (req_xfer),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   rde_divider #(
      .NUM_W (rde_pkg::Y_NUM_W),
      .DEN_W (rde_pkg::Y_DEN_W)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (num_ff),
      .denominator (den_ff),
      .quotient    (div_quotient),
      .status      (div_status)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_median_rssi   = rsp_median_ff;
   assign rsp_raw_distance  = rsp_raw_ff;
   assign rsp_mean_distance = rsp_mean_ff;

endmodule

### hdl/rde_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on rde_pkg for default sizes.
module rde_ram #(
   parameter int WIDTH = rde_pkg::DIST_W,
   parameter int DEPTH = rde_pkg::WINDOW_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= storage_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/rde_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on rde_pkg (status struct, default widths).
module rde_divider #(
   parameter int NUM_W = rde_pkg::Y_NUM_W,
   parameter int DEN_W = rde_pkg::Y_DEN_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NUM_W-1:0]            numerator,
   input  logic [DEN_W-1:0]            denominator,
   output logic [NUM_W-1:0]            quotient,
   output rde_pkg::div_status_type     status
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] count_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   trial_sub;
   logic             fits;
   logic [NUM_W-1:0] quo_in;
   logic [DEN_W-1:0] rem_in;

   always_comb begin
      trial     = {rem_ff, quo_ff[NUM_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits      = (trial >= {1'b0, den_ff});
      rem_in    = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_in    = {quo_ff[NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numerator;
         rem_ff <= '0;
         den_ff <= denominator;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient           = quo_ff;
   assign status.done        = done_ff;
   assign status.rem_nonzero = |rem_ff;

endmodule

### hdl/rde_checker.sv
// Port-level assertions for the RSSI distance estimator, bound to the top level.
// Depends on rde_pkg and rssi_distance_estimator_macros.svh.
`include "rssi_distance_estimator_macros.svh"

module rde_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [rde_pkg::RSSI_W-1:0]   rsp_median_rssi,
   input logic [rde_pkg::DIST_W-1:0]          rsp_raw_distance,
   input logic [rde_pkg::DIST_W-1:0]          rsp_mean_distance
);

   `RDE_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid, "rsp_valid after reset")

   `RDE_ASSERT_NEXT(a_one_item_in_flight, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

   `RDE_ASSERT_SAME(a_rsp_only_when_busy, clock, reset, $rose(rsp_valid), $past(!req_ready), "result without work in flight")

   `RDE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_median_rssi) && $stable(rsp_raw_distance) && $stable(rsp_mean_distance), "stalled result changed")

endmodule

bind rssi_distance_estimator rde_checker u_rde_checker (.*);

### test/tb_top.sv
// Self-checking bench for rssi_distance_estimator: directed table, then random phases.
// Predicts median, path-loss distance and windowed mean per transfer.
// Depends on rde_pkg and the estimator RTL.
module tb_top;

   localparam int TOTAL_ITEMS  = 1950;
   localparam int QUIET_ITEMS  = 150;
   localparam int HOLD_AT      = 700;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 100;
   localparam int MAX_REPORTS  = 50;
   localparam int RING_DEPTH   = rde_pkg::WINDOW_DEFAULT;

   localparam longint LOG2_TEN_Q16 = 217706;

   localparam logic [2:0] CHK_NONE   = 3'b000;
   localparam logic [2:0] CHK_MEDIAN = 3'b001;
   localparam logic [2:0] CHK_RAW    = 3'b010;
   localparam logic [2:0] CHK_MEAN   = 3'b100;
   localparam logic [2:0] CHK_ALL    = 3'b111;

   typedef struct packed {
      logic signed [rde_pkg::RSSI_W-1:0] median;
      logic [rde_pkg::DIST_W-1:0]        raw;
      logic [rde_pkg::DIST_W-1:0]        mean;
   } estimate_type;

   typedef enum logic [0:0] {
      ROW_SETTING,
      ROW_SAMPLE
   } row_kind_type;

   typedef struct packed {
      row_kind_type                      kind;
      logic signed [rde_pkg::RSSI_W-1:0] level;
      logic [rde_pkg::EXP_W-1:0]         exponent;
      logic [2:0]                        typed;
      estimate_type                      want;
   } stim_row_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic signed [rde_pkg::RSSI_W-1:0]  req_rssi_sample;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic signed [rde_pkg::RSSI_W-1:0]  rsp_median_rssi;
   logic [rde_pkg::DIST_W-1:0]         rsp_raw_distance;
   logic [rde_pkg::DIST_W-1:0]         rsp_mean_distance;
   logic                               csr_write_enable;
   logic [rde_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [rde_pkg::CSR_DATA_W-1:0]     csr_write_data;

   // predictor state
   logic signed [rde_pkg::RSSI_W-1:0]  ref_dbm  = rde_pkg::RSSI_AT_ONE_METRE_RESET;
   logic [rde_pkg::EXP_W-1:0]          loss_exp = rde_pkg::PATH_LOSS_EXPONENT_RESET;
   logic signed [rde_pkg::RSSI_W-1:0]  hist [0:2] = '{8'sd0, 8'sd0, 8'sd0};
   longint                             ring [0:RING_DEPTH-1];
   longint                             ring_sum  = 0;
   int                                 ring_slot = 0;

   longint pow2_q16 [0:16] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
                               92682, 96785, 101070, 105545, 110218, 115098, 120194,
                               125515, 131072};

   estimate_type pending_estimates [$];
   stim_row_type directed_rows [$];

   int   mismatch_count = 0;
   int   sent_count     = 0;
   int   stall_cycles;
   int   sink_wait      = 0;
   logic hold_request   = 1'b0;
   logic hold_served    = 1'b0;
   logic quiet          = 1'b0;

   rssi_distance_estimator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rssi_sample   (req_rssi_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_median_rssi   (rsp_median_rssi),
      .rsp_raw_distance  (rsp_raw_distance),
      .rsp_mean_distance (rsp_mean_distance),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint floor_quot(input longint num, input longint den);
      longint q;
      q = num / den;
      if (num < 0 && q * den != num) q = q - 1;
      return q;
   endfunction

   function automatic logic signed [rde_pkg::RSSI_W-1:0] median_of_three(
      input logic signed [rde_pkg::RSSI_W-1:0] a,
      input logic signed [rde_pkg::RSSI_W-1:0] b,
      input logic signed [rde_pkg::RSSI_W-1:0] c);
      logic signed [rde_pkg::RSSI_W-1:0] lo_ab;
      logic signed [rde_pkg::RSSI_W-1:0] hi_ab;
      logic signed [rde_pkg::RSSI_W-1:0] capped;
      lo_ab  = (a < b) ? a : b;
      hi_ab  = (a < b) ? b : a;
      capped = (hi_ab < c) ? hi_ab : c;
      return (lo_ab > capped) ? lo_ab : capped;
   endfunction

   // 10^((ref - median) / (10 n)) as 2^(x log2 10), Q16.8 metres
   function automatic logic [rde_pkg::DIST_W-1:0] path_loss_distance(
      input logic signed [rde_pkg::RSSI_W-1:0] med);
      longint diff;
      longint expo;
      longint y;
      longint k;
      longint f;
      longint idx;
      longint m;
      longint scaled;
      diff = longint'(ref_dbm) - longint'(med);
      expo = (loss_exp == '0) ? 1 : longint'(loss_exp);
      y    = floor_quot(diff * 16 * LOG2_TEN_Q16, 10 * expo);
      k    = floor_quot(y, 65536);
      f    = y - k * 65536;
      idx  = f / 4096;
      m    = pow2_q16[idx] + (((pow2_q16[idx+1] - pow2_q16[idx]) * (f % 4096)) / 4096);
      if (k >= 16) return '1;
      if (k >= 8) begin
         scaled = m << (k - 8);
         return (scaled > 16777215) ? '1 : scaled[23:0];
      end
      if (8 - k >= 32) return '0;
      scaled = m >> (8 - k);
      return scaled[23:0];
   endfunction

   function automatic estimate_type estimate_next(input logic signed [rde_pkg::RSSI_W-1:0] s);
      estimate_type e;
      hist[2]  = hist[1];
      hist[1]  = hist[0];
      hist[0]  = s;
      e.median = median_of_three(hist[0], hist[1], hist[2]);
      e.raw    = path_loss_distance(e.median);
      ring_sum = ring_sum - ring[ring_slot] + longint'(e.raw);
      ring[ring_slot] = longint'(e.raw);
      ring_slot = (ring_slot + 1) % RING_DEPTH;
      e.mean   = 24'(ring_sum / RING_DEPTH);
      return e;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic check_estimate();
      estimate_type want;
      if (pending_estimates.size() == 0) begin
         report_mismatch("result with nothing pending, median_rssi", rsp_median_rssi, 0);
         return;
      end
      want = pending_estimates.pop_front();
      if (rsp_median_rssi !== want.median)
         report_mismatch("median_rssi", rsp_median_rssi, want.median);
      if (rsp_raw_distance !== want.raw)
         report_mismatch("raw_distance", rsp_raw_distance, want.raw);
      if (rsp_mean_distance !== want.mean)
         report_mismatch("mean_distance", rsp_mean_distance, want.mean);
   endtask

   task automatic add_sample(input logic signed [7:0] level, input logic [2:0] typed,
                             input logic signed [7:0] med, input int raw, input int mean);
      stim_row_type row;
      row.kind        = ROW_SAMPLE;
      row.level       = level;
      row.exponent    = '0;
      row.typed       = typed;
      row.want.median = med;
      row.want.raw    = raw[23:0];
      row.want.mean   = mean[23:0];
      directed_rows.push_back(row);
   endtask

   task automatic add_setting(input logic signed [7:0] dbm, input logic [6:0] expo);
      stim_row_type row;
      row          = '0;
      row.kind     = ROW_SETTING;
      row.level    = dbm;
      row.exponent = expo;
      directed_rows.push_back(row);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clock);
   endtask

   task automatic apply_setting(input logic signed [7:0] dbm, input logic [6:0] expo);
      wait_for_drain();
      csr_write_enable <= 1'b1;
      csr_index        <= rde_pkg::CSR_RSSI_AT_ONE_METRE;
      csr_write_data   <= dbm;
      @(posedge clock);
      csr_index        <= rde_pkg::CSR_PATH_LOSS_EXPONENT;
      csr_write_data   <= {1'b0, expo};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      ref_dbm  = dbm;
      loss_exp = expo;
   endtask

   task automatic offer_sample(input logic signed [7:0] s, input logic [2:0] typed,
                               input estimate_type want);
      int           gap;
      estimate_type expected;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_rssi_sample <= s;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      expected = estimate_next(s);
      if ((typed & CHK_MEDIAN) != 0) expected.median = want.median;
      if ((typed & CHK_RAW) != 0) expected.raw = want.raw;
      if ((typed & CHK_MEAN) != 0) expected.mean = want.mean;
      pending_estimates.push_back(expected);
      sent_count++;
   endtask

   // result side: check each transfer, then pick next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         sink_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_estimate();
         if (hold_request && !hold_served) begin
            sink_wait   = HOLD_CYCLES;
            hold_served = 1'b1;
         end
         if (sink_wait > 0) begin
            sink_wait--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            sink_wait = $urandom_range(1, 19) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("rssi_distance_estimator: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      stim_row_type            row;
      estimate_type            none;
      logic signed [7:0]       level;
      int                      phase_len;
      int                      near;
      int                      ref_pick;
      int                      exp_pick;
      int                      n;

      for (n = 0; n < RING_DEPTH; n++) ring[n] = 0;
      none             = '0;
      level            = '0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_rssi_sample  = '0;
      csr_write_enable = 1'b0;
      csr_index        = rde_pkg::CSR_RSSI_AT_ONE_METRE;
      csr_write_data   = '0;

      // zeros from reset take part in median and mean
      add_sample(8'sd0, CHK_ALL, 8'sd0, 0, 0);
      add_sample(8'sd127, CHK_ALL, 8'sd0, 0, 0);
      add_sample(-8'sd128, CHK_ALL, 8'sd0, 0, 0);
      // median equal to the one-metre level: exactly 1.0 m
      add_sample(-8'sd59, CHK_ALL, -8'sd59, 256, 32);
      add_sample(-8'sd59, CHK_ALL, -8'sd59, 256, 64);
      add_sample(-8'sd1, CHK_NONE, 0, 0, 0);
      add_sample(-8'sd75, CHK_NONE, 0, 0, 0);
      // far beyond full scale: saturation
      add_setting(8'sd0, 7'd8);
      add_sample(-8'sd128, CHK_NONE, 0, 0, 0);
      add_sample(-8'sd128, CHK_MEDIAN | CHK_RAW, -8'sd128, 24'hFFFFFF, 0);
      add_sample(-8'sd128, CHK_MEDIAN | CHK_RAW, -8'sd128, 24'hFFFFFF, 0);
      // far below resolution: truncates to zero
      add_setting(-8'sd128, 7'd127);
      add_sample(8'sd127, CHK_MEDIAN | CHK_RAW, -8'sd128, 256, 0);
      add_sample(8'sd127, CHK_MEDIAN | CHK_RAW, 8'sd127, 0, 0);
      add_sample(8'sd127, CHK_MEDIAN | CHK_RAW, 8'sd127, 0, 0);
      // zero exponent acts as 1/16
      add_setting(-8'sd128, 7'd0);
      add_sample(-8'sd128, CHK_NONE, 0, 0, 0);
      add_sample(-8'sd128, CHK_MEDIAN | CHK_RAW, -8'sd128, 256, 0);
      add_sample(-8'sd127, CHK_MEDIAN | CHK_RAW, -8'sd128, 256, 0);
      add_sample(-8'sd120, CHK_NONE, 0, 0, 0);
      add_setting(-8'sd1, 7'd1);
      add_sample(-8'sd40, CHK_NONE, 0, 0, 0);
      add_sample(8'sd0, CHK_NONE, 0, 0, 0);
      add_sample(8'sd100, CHK_NONE, 0, 0, 0);
      add_setting(8'sd127, 7'd127);
      add_sample(8'sd127, CHK_NONE, 0, 0, 0);
      add_setting(rde_pkg::RSSI_AT_ONE_METRE_RESET, rde_pkg::PATH_LOSS_EXPONENT_RESET);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_SETTING) apply_setting(row.level, row.exponent);
         else offer_sample(row.level, row.typed, row.want);
      end

      while (sent_count < TOTAL_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       ref_pick = -128;
            1:       ref_pick = 0;
            2:       ref_pick = int'($urandom_range(0, 255));
            default: ref_pick = -int'($urandom_range(30, 90));
         endcase
         case ($urandom_range(0, 5))
            0:       exp_pick = 8;
            1:       exp_pick = 127;
            2:       exp_pick = int'($urandom_range(0, 7));
            default: exp_pick = int'($urandom_range(8, 127));
         endcase
         apply_setting(ref_pick[7:0], exp_pick[6:0]);
         phase_len = $urandom_range(20, 200);
         for (n = 0; n < phase_len && sent_count < TOTAL_ITEMS; n++) begin
            case ($urandom_range(0, 9)) inside
               [0:1]:   level = 8'($urandom_range(0, 255));
               [2:3]:   level = level;
               default: begin
                  near = int'(ref_dbm) + 10 - int'($urandom_range(0, 70));
                  if (near < -128) near = -128;
                  if (near > 127) near = 127;
                  level = near[7:0];
               end
            endcase
            offer_sample(level, CHK_NONE, none);
            if (sent_count == HOLD_AT) hold_request <= 1'b1;
            if (sent_count == TOTAL_ITEMS - QUIET_ITEMS) quiet <= 1'b1;
         end
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_estimates.size() == 0)
         $display("rssi_distance_estimator: match");
      else
         $display("rssi_distance_estimator: mismatch");
      $finish;
   end

endmodule
